FILE: rtl/core/ascii_command_register_parser_top_macros.svh
// assertion macros shared by the parser checker
`ifndef ASCII_COMMAND_REGISTER_PARSER_TOP_MACROS_SVH
`define ASCII_COMMAND_REGISTER_PARSER_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define ACRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acrp check failed");

// condition implies consequence in the next cycle
`define ACRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acrp check failed");

`endif

FILE: rtl/core/acrp_pkg.sv
// shared types and character constants of the ascii command parser
`default_nettype none

package acrp_pkg;

    localparam int unsigned RX_W   = 8;
    localparam int unsigned VAL_W  = 7;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned TRK_W  = 2;
    localparam int unsigned OUT_W  = 40;

    // command letters and the digit bounds
    localparam logic [RX_W-1:0] CH_V    = 8'h56;
    localparam logic [RX_W-1:0] CH_D    = 8'h44;
    localparam logic [RX_W-1:0] CH_P    = 8'h50;
    localparam logic [RX_W-1:0] CH_I    = 8'h49;
    localparam logic [RX_W-1:0] CH_T    = 8'h54;
    localparam logic [RX_W-1:0] CH_S    = 8'h53;
    localparam logic [RX_W-1:0] CH_ZERO = 8'h30;
    localparam logic [RX_W-1:0] CH_NINE = 8'h39;

    // S command codes as two bcd digits
    localparam logic [7:0] S_SAVE       = 8'h15;
    localparam logic [7:0] S_RUN_ON     = 8'h20;
    localparam logic [7:0] S_RUN_OFF    = 8'h25;
    localparam logic [7:0] S_REMOTE_ON  = 8'h30;
    localparam logic [7:0] S_REMOTE_OFF = 8'h35;
    localparam logic [7:0] S_SWITCH_ON  = 8'h40;
    localparam logic [7:0] S_SWITCH_OFF = 8'h45;
    localparam logic [7:0] S_TRACK_TWO  = 8'h50;
    localparam logic [7:0] S_TRACK_ONE  = 8'h55;

    localparam logic [TRK_W-1:0] TRACK_ONE = 2'd1;
    localparam logic [TRK_W-1:0] TRACK_TWO = 2'd2;

    // result item, first member ends up in the highest bits
    typedef struct packed {
        logic             save_request;
        logic [TRK_W-1:0] track_type;
        logic             switch_enable;
        logic             remote_enable;
        logic             run_enable;
        logic [DIG_W-1:0] pwm_mode;
        logic [VAL_W-1:0] ki_thousandths;
        logic [VAL_W-1:0] kd_tenths;
        logic [VAL_W-1:0] kp_tenths;
        logic [VAL_W-1:0] speed_target;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/ascii_command_register_parser_top.sv
// A result passes through the input register and then the result register after the byte that completes a command.
// Throughput: one byte per cycle while results are taken; a stalled result holds the byte in
// the input register and drops tready until the result transfer.
// Bytes that do not fit the expected position are dropped and give no result.
// Reset (i_rst_n low, synchronous) clears the parse position, settings and valid flags;
// settings restart at zero with track type one.
`default_nettype none

module ascii_command_register_parser_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] rx_byte
    input  wire  [acrp_pkg::RX_W-1:0]             i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // [6:0] speed_target, [13:7] kp_tenths, [20:14] kd_tenths, [27:21] ki_thousandths,
    // [31:28] pwm_mode, [32] run_enable, [33] remote_enable, [34] switch_enable,
    // [36:35] track_type, [37] save_request, [39:38] zero
    output logic [acrp_pkg::OUT_W-1:0]            o_m_axis_tdata
);
    import acrp_pkg::*;

    localparam logic [1:0] POS_LETTER = 2'd0;
    localparam logic [1:0] POS_DIG1   = 2'd1;
    localparam logic [1:0] POS_DIG2   = 2'd2;

    logic             r_in_valid;
    logic [RX_W-1:0]  r_in_byte;
    logic             r_out_valid;
    t_result          r_out;

    logic [1:0]       r_pos,   n_pos;
    logic [RX_W-1:0]  r_cmd,   n_cmd;
    logic [DIG_W-1:0] r_first, n_first;
    logic [VAL_W-1:0] r_speed, n_speed;
    logic [VAL_W-1:0] r_kp,    n_kp;
    logic [VAL_W-1:0] r_kd,    n_kd;
    logic [VAL_W-1:0] r_ki,    n_ki;
    logic [DIG_W-1:0] r_pwm,   n_pwm;
    logic [2:0]       r_flags, n_flags;
    logic [TRK_W-1:0] r_track, n_track;

    logic             out_free;
    logic             proc_fire;
    logic             is_digit;
    logic             is_letter;
    logic [DIG_W-1:0] lo;
    logic [VAL_W-1:0] val;
    logic             emit;
    logic             save;

    // handshake: the output register frees up as soon as its result is taken
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc_fire       = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || proc_fire;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

    // character classes and decimal value
    assign is_digit  = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_letter = (r_in_byte == CH_V) || (r_in_byte == CH_D) || (r_in_byte == CH_P) ||
                       (r_in_byte == CH_I) || (r_in_byte == CH_T) || (r_in_byte == CH_S);
    assign lo  = r_in_byte[DIG_W-1:0];
    assign val = ({3'b000, r_first} << 3) + ({3'b000, r_first} << 1) + {3'b000, lo};

    // parse step and settings update
    always_comb begin
        n_pos   = r_pos;
        n_cmd   = r_cmd;
        n_first = r_first;
        n_speed = r_speed;
        n_kp    = r_kp;
        n_kd    = r_kd;
        n_ki    = r_ki;
        n_pwm   = r_pwm;
        n_flags = r_flags;
        n_track = r_track;
        emit    = 1'b0;
        save    = 1'b0;
        if (proc_fire) begin
            unique case (r_pos)
                POS_LETTER: begin
                    if (is_letter) begin
                        n_cmd = r_in_byte;
                        n_pos = POS_DIG1;
                    end
                end
                POS_DIG1: begin
                    if (is_digit) begin
                        n_first = r_in_byte[DIG_W-1:0];
                        n_pos   = POS_DIG2;
                    end
                end
                POS_DIG2: begin
                    if (is_digit) begin
                        emit  = 1'b1;
                        n_pos = POS_LETTER;
                        unique case (r_cmd)
                            CH_V:    n_speed = val;
                            CH_P:    n_kp    = val;
                            CH_D:    n_kd    = val;
                            CH_I:    n_ki    = val;
                            CH_T:    n_pwm   = r_first;
                            CH_S: begin
                                unique case ({r_first, lo})
                                    S_SAVE:       save       = 1'b1;
                                    S_RUN_ON:     n_flags[0] = 1'b1;
                                    S_RUN_OFF:    n_flags[0] = 1'b0;
                                    S_REMOTE_ON:  n_flags[1] = 1'b1;
                                    S_REMOTE_OFF: n_flags[1] = 1'b0;
                                    S_SWITCH_ON:  n_flags[2] = 1'b1;
                                    S_SWITCH_OFF: n_flags[2] = 1'b0;
                                    S_TRACK_TWO:  n_track    = TRACK_TWO;
                                    S_TRACK_ONE:  n_track    = TRACK_ONE;
                                    default:      save       = 1'b0;
                                endcase
                            end
                            default: n_pos = POS_LETTER;
                        endcase
                    end
                end
                default: begin
                    n_pos   = POS_LETTER;
                    n_cmd   = '0;
                    n_first = '0;
                end
            endcase
        end
    end

    // input register and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= POS_LETTER;
            r_cmd      <= '0;
            r_first    <= '0;
            r_speed    <= '0;
            r_kp       <= '0;
            r_kd       <= '0;
            r_ki       <= '0;
            r_pwm      <= '0;
            r_flags    <= '0;
            r_track    <= TRACK_ONE;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            r_pos   <= n_pos;
            r_cmd   <= n_cmd;
            r_first <= n_first;
            r_speed <= n_speed;
            r_kp    <= n_kp;
            r_kd    <= n_kd;
            r_ki    <= n_ki;
            r_pwm   <= n_pwm;
            r_flags <= n_flags;
            r_track <= n_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.save_request   <= save;
            r_out.track_type     <= n_track;
            r_out.switch_enable  <= n_flags[2];
            r_out.remote_enable  <= n_flags[1];
            r_out.run_enable     <= n_flags[0];
            r_out.pwm_mode       <= n_pwm;
            r_out.ki_thousandths <= n_ki;
            r_out.kd_tenths      <= n_kd;
            r_out.kp_tenths      <= n_kp;
            r_out.speed_target   <= n_speed;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/acrp_checker.sv
// port-level checks for the ascii command parser, bound to its top level
`default_nettype none

`include "ascii_command_register_parser_top_macros.svh"

module acrp_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_axis_tvalid,
    input wire                             o_s_axis_tready,
    input wire [acrp_pkg::RX_W-1:0]        i_s_axis_tdata,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready,
    input wire [acrp_pkg::OUT_W-1:0]       o_m_axis_tdata
);
    import acrp_pkg::*;

    logic stalled;
    logic rx_seen;

    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;
    assign rx_seen = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata != '0);

    // a stalled result stays offered and unchanged
    `ACRP_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, stalled, o_m_axis_tvalid)
    `ACRP_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, stalled, $stable(o_m_axis_tdata))

    // track type only ever one or two
    `ACRP_ASSERT_NOW(a_track_range, i_clk, i_rst_n, o_m_axis_tvalid,
        (o_m_axis_tdata[36:35] == TRACK_ONE) || (o_m_axis_tdata[36:35] == TRACK_TWO))

    // pwm mode is a single decimal digit and padding stays zero
    `ACRP_ASSERT_NOW(a_pwm_digit, i_clk, i_rst_n, o_m_axis_tvalid || rx_seen,
        !o_m_axis_tvalid || ((o_m_axis_tdata[31:28] <= 4'd9) && (o_m_axis_tdata[39:38] == 2'b00)))

endmodule

bind ascii_command_register_parser_top acrp_checker u_acrp_checker (.*);

`default_nettype wire
